// File: rtl/rc4_stream_cipher_assert.svh
// ---------------------------------------------------------------------------
// RC4 cipher assertion macros
// Shared property forms for the concurrent checks in the RC4 cipher RTL.
// ---------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rc4_pkg.sv
// ---------------------------------------------------------------------------
// RC4 cipher package
// Types, opcodes, controller states and the command and status bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int LEN_W      = 9;
    localparam int OP_W       = 2;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_KEY = 2'd0,
        OP_SCHEDULE = 2'd1,
        OP_CIPHER   = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DATA_RD_J,
        ST_DATA_RD_T,
        ST_DATA_OUT,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_KS_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_wr;
        logic ks_start;
        logic data_start;
        logic data_rd_j;
        logic data_rd_t;
        logic data_wr_j;
        logic ks_rd_n;
        logic ks_rd_j;
        logic ks_wr_n;
        logic ks_wr_j;
        logic ks_done;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
        logic ks_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/rc4_sbox.sv
// ---------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 table with one read and one write port, registered read data and
// a valid bit per entry so that a cleared entry reads back as its own index.
// ---------------------------------------------------------------------------
`default_nettype none

module rc4_sbox (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clear,
    input  wire logic          rd_en,
    input  wire rc4_pkg::byte_t rd_addr,
    output      rc4_pkg::byte_t rd_data,
    input  wire logic          wr_en,
    input  wire rc4_pkg::byte_t wr_addr,
    input  wire rc4_pkg::byte_t wr_data
);
    import rc4_pkg::*;

    byte_t                 perm_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] valid_reg;
    byte_t                 rd_q_reg;
    byte_t                 rd_addr_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            perm_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= perm_mem[rd_addr];
            rd_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // An entry not written since the last clear holds the identity value.
    assign rd_data = rd_valid_reg ? rd_q_reg : rd_addr_reg;

endmodule

`default_nettype wire

// File: rtl/rc4_ctrl.sv
// ---------------------------------------------------------------------------
// RC4 controller
// Sequences key loads, the key schedule and keystream steps for the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rc4_stream_cipher_assert.svh"

module rc4_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output      logic             s_tready,
    input  wire rc4_pkg::opcode_t opcode,
    input  wire rc4_pkg::status_t status,
    output      rc4_pkg::cmd_t    cmd
);
    import rc4_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (opcode)
                        OP_SCHEDULE: begin
                            state_next = status.len_zero ? ST_IDLE : ST_KS_RD_N;
                        end
                        OP_CIPHER:   state_next = ST_DATA_RD_J;
                        OP_LOAD_KEY: state_next = ST_IDLE;
                        OP_NONE:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DATA_RD_J: state_next = ST_DATA_RD_T;
            ST_DATA_RD_T: state_next = ST_DATA_OUT;
            ST_DATA_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_KS_RD_N: state_next = ST_KS_RD_J;
            ST_KS_RD_J: state_next = ST_KS_WR_N;
            ST_KS_WR_N: state_next = ST_KS_WR_J;
            ST_KS_WR_J: state_next = status.ks_last ? ST_KS_DONE : ST_KS_RD_N;
            ST_KS_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.key_wr     = (opcode == OP_LOAD_KEY);
                    cmd.ks_start   = (opcode == OP_SCHEDULE);
                    cmd.data_start = (opcode == OP_CIPHER);
                end
            end
            ST_DATA_RD_J: cmd.data_rd_j = 1'b1;
            ST_DATA_RD_T: cmd.data_rd_t = 1'b1;
            ST_DATA_OUT: begin
                // The swap write is repeated harmlessly while the output waits.
                cmd.data_wr_j = 1'b1;
                cmd.out_load  = status.out_free;
            end
            ST_KS_RD_N: cmd.ks_rd_n = 1'b1;
            ST_KS_RD_J: cmd.ks_rd_j = 1'b1;
            ST_KS_WR_N: cmd.ks_wr_n = 1'b1;
            ST_KS_WR_J: cmd.ks_wr_j = 1'b1;
            ST_KS_DONE: begin
                cmd.ks_done  = 1'b1;
                cmd.out_load = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

    `RC4_ASSERT_SAME(a_load_when_free, aclk, aresetn, cmd.out_load, status.out_free,
        "result loaded while output register still occupied")
    `RC4_ASSERT_NEXT(a_last_step_done, aclk, aresetn,
        (state_reg == ST_KS_WR_J) && status.ks_last, state_reg == ST_KS_DONE,
        "key schedule did not finish after its last swap step")

endmodule

`default_nettype wire

// File: rtl/rc4_datapath.sv
// ---------------------------------------------------------------------------
// RC4 datapath
// Indices, key store, permutation memory, configuration and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rc4_stream_cipher_assert.svh"

module rc4_datapath #(
    parameter int KEY_MAX = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire rc4_pkg::cmd_t    cmd,
    output      rc4_pkg::status_t status,
    input  wire rc4_pkg::byte_t   key_index,
    input  wire rc4_pkg::byte_t   data_byte,
    input  wire logic             cfg_wr_en,
    input  wire rc4_pkg::len_t    cfg_wr_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      rc4_pkg::byte_t   out_byte,
    output      logic             out_done
);
    import rc4_pkg::*;

    localparam int   KIDX_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam len_t KEY_MAX_V = len_t'(KEY_MAX);

    typedef enum logic [1:0] {
        BYP_NONE,
        BYP_SI,
        BYP_SJ
    } byp_t;

    len_t              key_length_reg;
    len_t              len_eff;
    byte_t             key_mem [KEY_MAX];
    byte_t             key_q_reg;
    logic [KIDX_W-1:0] k_reg;
    logic [KIDX_W-1:0] k_next;
    len_t              k_inc;
    byte_t             i_reg;
    byte_t             j_reg;
    byte_t             data_reg;
    byte_t             si_reg;
    byte_t             sj_reg;
    byp_t              byp_reg;
    byp_t              byp_next;
    logic              out_valid_reg;
    byte_t             out_byte_reg;
    logic              out_done_reg;

    byte_t             perm_rd;
    logic              perm_rd_en;
    byte_t             perm_rd_addr;
    logic              perm_wr_en;
    byte_t             perm_wr_addr;
    byte_t             perm_wr_data;
    byte_t             t_addr;
    byte_t             ks_byte;

    rc4_sbox u_sbox (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cmd.ks_start),
        .rd_en   (perm_rd_en),
        .rd_addr (perm_rd_addr),
        .rd_data (perm_rd),
        .wr_en   (perm_wr_en),
        .wr_addr (perm_wr_addr),
        .wr_data (perm_wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= KEY_LEN_RESET;
        end else if (cfg_wr_en) begin
            key_length_reg <= cfg_wr_data;
        end
    end

    assign len_eff = (key_length_reg > KEY_MAX_V) ? KEY_MAX_V : key_length_reg;

    // Key store: written by load transfers, read once per schedule step.
    always_ff @(posedge aclk) begin
        if (cmd.key_wr && ({1'b0, key_index} < KEY_MAX_V)) begin
            key_mem[key_index[KIDX_W-1:0]] <= data_byte;
        end
        if (cmd.ks_rd_n) begin
            key_q_reg <= key_mem[k_reg];
        end
    end

    assign t_addr = si_reg + perm_rd;

    always_comb begin
        perm_rd_en   = cmd.data_start || cmd.data_rd_j || cmd.data_rd_t ||
                       cmd.ks_rd_n || cmd.ks_rd_j;
        perm_rd_addr = i_reg;
        priority if (cmd.data_start) begin
            perm_rd_addr = i_reg + 8'd1;
        end else if (cmd.data_rd_j) begin
            perm_rd_addr = j_reg + perm_rd;
        end else if (cmd.data_rd_t) begin
            perm_rd_addr = t_addr;
        end else if (cmd.ks_rd_j) begin
            perm_rd_addr = j_reg + key_q_reg + perm_rd;
        end else begin
            perm_rd_addr = i_reg;
        end
    end

    always_comb begin
        perm_wr_en   = cmd.data_rd_t || cmd.data_wr_j || cmd.ks_wr_n || cmd.ks_wr_j;
        perm_wr_addr = (cmd.data_wr_j || cmd.ks_wr_j) ? j_reg : i_reg;
        perm_wr_data = (cmd.data_wr_j || cmd.ks_wr_j) ? si_reg : perm_rd;
    end

    // The final keystream read is issued before both swap writes land, so
    // an address that hits either swapped entry takes the new value directly.
    always_comb begin
        if (t_addr == j_reg) begin
            byp_next = BYP_SI;
        end else if (t_addr == i_reg) begin
            byp_next = BYP_SJ;
        end else begin
            byp_next = BYP_NONE;
        end
    end

    always_comb begin
        unique case (byp_reg)
            BYP_SI:   ks_byte = si_reg;
            BYP_SJ:   ks_byte = sj_reg;
            default:  ks_byte = perm_rd;
        endcase
    end

    assign k_inc  = len_t'(k_reg) + len_t'(1);
    assign k_next = (k_inc >= len_eff) ? '0 : k_inc[KIDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end else begin
            if (cmd.ks_start) begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end
            if (cmd.data_start) begin
                i_reg <= i_reg + 8'd1;
            end
            if (cmd.data_rd_j) begin
                j_reg <= j_reg + perm_rd;
            end
            if (cmd.ks_rd_j) begin
                j_reg <= j_reg + key_q_reg + perm_rd;
            end
            if (cmd.ks_wr_j) begin
                i_reg <= i_reg + 8'd1;
                k_reg <= k_next;
            end
            if (cmd.ks_done) begin
                j_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.data_start) begin
            data_reg <= data_byte;
        end
        if (cmd.data_rd_j || cmd.ks_rd_j) begin
            si_reg <= perm_rd;
        end
        if (cmd.data_rd_t) begin
            sj_reg  <= perm_rd;
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_byte_reg <= cmd.ks_done ? '0 : (data_reg ^ ks_byte);
            out_done_reg <= cmd.ks_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_done  = out_done_reg;

    assign status.len_zero = (len_eff == '0);
    assign status.ks_last  = (i_reg == 8'hff);
    assign status.out_free = !out_valid_reg || out_ready;

    `RC4_ASSERT_SAME(a_done_byte_zero, aclk, aresetn, out_valid_reg && out_done_reg,
        out_byte_reg == '0, "schedule completion result carries a non-zero byte")
    `RC4_ASSERT_SAME(a_sched_wrapped, aclk, aresetn, cmd.ks_done, i_reg == '0,
        "key schedule ended without index i back at zero")

endmodule

`default_nettype wire

// File: rtl/rc4_stream_cipher.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher engine
// Key load transfers leave the controller idle, so they are taken back to back.
// A cipher byte passes through ST_DATA_RD_J, ST_DATA_RD_T and ST_DATA_OUT, set by
// three dependent permutation table reads, and no new input is taken until idle.
// A key schedule runs its read and swap steps over all 256 entries and gives a
// completion result before the next input; a zero key length gives no result.
// A result held by m_tready stalls the next result in its last cycle; reset gives
// the identity table at once.
// ---------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
    parameter int KEY_MAX = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,    // key_index [7:0], data_byte [15:8]
    input  wire logic [1:0]  s_tuser,    // opcode [1:0]
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,    // out_byte [7:0]
    output      logic [0:0]  m_tuser,    // schedule_done [0]
    input  wire logic        cfg_wr_en,
    input  wire logic [8:0]  cfg_wr_data // key_length [8:0]
);
    import rc4_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    out_done;

    rc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (opcode_t'(s_tuser)),
        .status   (status),
        .cmd      (cmd)
    );

    rc4_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .key_index   (s_tdata[7:0]),
        .data_byte   (s_tdata[15:8]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_done    (out_done)
    );

    assign m_tuser = out_done;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives key loads, key schedules, cipher bytes and ignored commands through
// the input stream, predicts every result with its own copy of the
// permutation, indices and key store, and checks each result transfer in
// order. Both stream sides idle in short random bursts, and the key length
// register is moved through its extremes between phases.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rc4_pkg::*;

    localparam int SCHEDULE_CYCLES = 4 * 256 + 2;
    localparam int SETTLE_CYCLES   = SCHEDULE_CYCLES + 64;
    localparam int WATCHDOG_LIMIT  = 8 * SETTLE_CYCLES;
    localparam int RANDOM_ITEMS    = 1550;

    typedef struct packed {
        byte_t out_byte;
        logic  done;
    } cipher_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // key_index [7:0], data_byte [15:8]
    logic [1:0]  s_tuser = '0;     // opcode [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // out_byte [7:0]
    logic [0:0]  m_tuser;          // schedule_done [0]
    logic        cfg_wr_en = 1'b0;
    logic [8:0]  cfg_wr_data = '0; // key_length [8:0]

    // Predicted engine state.
    byte_t perm_tbl [256];
    byte_t key_tbl [256];
    bit    key_set [256];
    byte_t ptr_i;
    byte_t ptr_j;
    len_t  key_len;

    cipher_result_t expected_out [$];
    int  mismatches = 0;
    int  items_sent = 0;
    bit  idling = 1'b0;
    int  stall_left = 0;
    int  quiet_cycles = 0;

    rc4_stream_cipher #(
        .KEY_MAX (256)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void reset_permutation();
        for (int k = 0; k < 256; k++) perm_tbl[k] = byte_t'(k);
        ptr_i = '0;
        ptr_j = '0;
    endfunction

    function automatic int effective_key_len();
        return (key_len > 256) ? 256 : int'(key_len);
    endfunction

    // Returns 1 when the schedule gives a completion result.
    function automatic bit schedule_permutation();
        int    eff;
        int    kpos;
        byte_t jj;
        byte_t sn;
        reset_permutation();
        eff = effective_key_len();
        if (eff == 0) return 1'b0;
        jj = '0;
        kpos = 0;
        for (int n = 0; n < 256; n++) begin
            sn = perm_tbl[n];
            jj = jj + key_tbl[kpos] + sn;
            perm_tbl[n] = perm_tbl[jj];
            perm_tbl[jj] = sn;
            kpos = (kpos + 1 == eff) ? 0 : kpos + 1;
        end
        return 1'b1;
    endfunction

    function automatic byte_t next_keystream();
        byte_t si;
        byte_t sj;
        ptr_i = ptr_i + 8'd1;
        si = perm_tbl[ptr_i];
        ptr_j = ptr_j + si;
        sj = perm_tbl[ptr_j];
        perm_tbl[ptr_i] = sj;
        perm_tbl[ptr_j] = si;
        return perm_tbl[byte_t'(si + sj)];
    endfunction

    function automatic void predict_transfer(opcode_t op, byte_t idx, byte_t data);
        cipher_result_t res;
        case (op)
            OP_LOAD_KEY: begin
                key_tbl[idx] = data;
                key_set[idx] = 1'b1;
            end
            OP_SCHEDULE: begin
                if (schedule_permutation()) begin
                    res.out_byte = '0;
                    res.done = 1'b1;
                    expected_out.push_back(res);
                end
            end
            OP_CIPHER: begin
                res.out_byte = data ^ next_keystream();
                res.done = 1'b0;
                expected_out.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // The item stays on the bus until the transfer; valid is only lowered for a gap.
    task automatic send_item(opcode_t op, byte_t idx, byte_t data);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_transfer(op, idx, data);
        if (op != OP_NONE) items_sent++;
    endtask

    task automatic wait_results_idle(int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // A schedule of zero length gives no result, so the full schedule time is
    // allowed to pass before the register is touched.
    task automatic write_key_length(int value);
        wait_results_idle(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 9'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        key_len = len_t'(value);
    endtask

    // Key loads (every missing entry in range plus random reloads), a
    // schedule in most sessions, then a run of cipher bytes with occasional noise.
    task automatic run_session();
        int eff;
        int ncip;
        eff = effective_key_len();
        for (int k = 0; k < eff; k++) begin
            if (!key_set[k] || $urandom_range(0, 3) == 0)
                send_item(OP_LOAD_KEY, byte_t'(k), byte_t'($urandom));
        end
        if ($urandom_range(0, 7) != 0) send_item(OP_SCHEDULE, byte_t'($urandom), byte_t'($urandom));
        ncip = $urandom_range(1, 40);
        for (int n = 0; n < ncip; n++) begin
            case ($urandom_range(0, 19))
                0: send_item(OP_NONE, byte_t'($urandom), byte_t'($urandom));
                1: send_item(OP_LOAD_KEY, byte_t'($urandom), byte_t'($urandom));
                default: send_item(OP_CIPHER, byte_t'($urandom), byte_t'($urandom));
            endcase
        end
        if ($urandom_range(0, 3) == 0) wait_results_idle(0);
    endtask

    task automatic test_identity_after_reset();
        send_item(OP_CIPHER, 8'h00, 8'h00);
        send_item(OP_CIPHER, 8'hff, 8'hff);
        send_item(OP_NONE, 8'hff, 8'hff);
        send_item(OP_CIPHER, 8'h00, 8'h5a);
    endtask

    task automatic test_single_byte_key();
        write_key_length(1);
        send_item(OP_LOAD_KEY, 8'h00, 8'hff);
        send_item(OP_LOAD_KEY, 8'hff, 8'h00);
        send_item(OP_SCHEDULE, 8'h00, 8'h00);
        send_item(OP_CIPHER, 8'h00, 8'h00);
        send_item(OP_CIPHER, 8'hff, 8'hff);
        send_item(OP_NONE, 8'h00, 8'h00);
        send_item(OP_CIPHER, 8'h00, 8'h3c);
    endtask

    task automatic test_zero_key_length();
        write_key_length(0);
        send_item(OP_SCHEDULE, 8'hff, 8'hff);
        send_item(OP_CIPHER, 8'h00, 8'h00);
        send_item(OP_CIPHER, 8'h00, 8'hff);
    endtask

    task automatic test_random_sessions();
        int extremes [9] = '{256, 511, 300, 2, 16, 0, 5, 1, 128};
        int phase;
        int stop_at;
        phase = 0;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if (phase < 9)
                write_key_length(extremes[phase]);
            else if ($urandom_range(0, 3) == 0)
                write_key_length($urandom_range(0, 511));
            else
                write_key_length($urandom_range(1, 24));
            repeat ($urandom_range(2, 4)) begin
                idling = ($urandom_range(0, 3) != 0);
                run_session();
            end
            phase++;
        end
    endtask

    task automatic test_quiet_tail();
        idling = 1'b0;
        write_key_length(16);
        run_session();
        run_session();
    endtask

    // Result side stalls in random bursts, only while idling is set.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cipher_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out.size() == 0) begin
                flag_mismatch("unexpected result transfer", m_tdata, 0);
            end else begin
                want = expected_out.pop_front();
                if (m_tdata !== want.out_byte) flag_mismatch("out_byte", m_tdata, want.out_byte);
                if (m_tuser[0] !== want.done)
                    flag_mismatch("schedule_done", m_tuser[0], want.done);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        reset_permutation();
        key_len = KEY_LEN_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity_after_reset();
        test_single_byte_key();
        test_zero_key_length();
        test_random_sessions();
        test_quiet_tail();
        wait_results_idle(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_sbox.sv
rtl/rc4_ctrl.sv
rtl/rc4_datapath.sv
rtl/rc4_stream_cipher.sv
tb/sv/tb.sv
